// ===== rtl/hlb_pkg.sv =====
// Shared types and constants for the height layer blend unit.
// Used by the channel interfaces and the top level; depends on nothing.
package hlb_pkg;

	// Field widths.
	localparam int H_W        = 24;
	localparam int Q_W        = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	// Fixed-point constants, Q.16.
	localparam int Q_ONE = 65536;
	localparam int Q_HALF = 32768;
	localparam logic [Q_W-1:0] Q_ONE_U = 17'h10000;
	localparam logic [Q_W-1:0] OPACITY_MIN = 17'd655;
	localparam logic signed [H_W-1:0] H_MAX = 24'sh7FFFFF;
	localparam logic signed [H_W-1:0] H_MIN = 24'sh800000;

	typedef enum logic [2:0] {
		MODE_NORMAL   = 3'd0,
		MODE_ADD      = 3'd1,
		MODE_SUBTRACT = 3'd2,
		MODE_MULTIPLY = 3'd3,
		MODE_SCREEN   = 3'd4,
		MODE_MAX      = 3'd5,
		MODE_MIN      = 3'd6,
		MODE_OVERLAY  = 3'd7
	} blend_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BLEND_MODE    = 2'd0,
		CFG_OPACITY       = 2'd1,
		CFG_LAYER_VISIBLE = 2'd2,
		CFG_MASK_ENABLED  = 2'd3
	} cfg_reg_t;

endpackage

// ===== rtl/hlb_pix_if.sv =====
// Pixel request channel of the height layer blend unit.
// Depends on hlb_pkg for the field widths.
interface hlb_pix_if;
	logic                             valid;
	logic                             ready;
	logic signed [hlb_pkg::H_W-1:0]   below_height;
	logic signed [hlb_pkg::H_W-1:0]   layer_height;
	logic        [hlb_pkg::Q_W-1:0]   mask_value;

	modport source (output valid, output below_height, output layer_height,
		output mask_value, input ready);
	modport sink (input valid, input below_height, input layer_height,
		input mask_value, output ready);
endinterface

// ===== rtl/hlb_res_if.sv =====
// Result channel of the height layer blend unit.
// Depends on hlb_pkg for the field width.
interface hlb_res_if;
	logic                             valid;
	logic                             ready;
	logic signed [hlb_pkg::H_W-1:0]   blended_height;

	modport source (output valid, output blended_height, input ready);
	modport sink (input valid, input blended_height, output ready);
endinterface

// ===== rtl/height_layer_blend_unit.sv =====
// Height layer blend unit: composites one terrain layer over the height below.
// Depends on hlb_pkg, hlb_pix_if and hlb_res_if.

// The unit takes one pixel request per cycle while its output is not stalled
// (height below, layer height and mask value) and returns one composited
// height per request, in order. It is a four-stage pipeline: stage one
// forms the opacity-mask factor and the overlay term, stage two applies the
// factor in one product, stage three does the second product needed by
// multiply and screen and the final add, and stage four saturates into the
// output register. A new request is accepted in every cycle while the output
// is taken; when the output stalls, empty stages still fill, so up to four
// requests are held before ready drops. Configuration registers are written
// through the plain write port and must only be changed while no request is
// in flight. When the layer is hidden or the opacity is 655 or less, the
// height below is passed through unchanged.
module height_layer_blend_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [hlb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hlb_pkg::CFG_DATA_W-1:0]    cfg_data,
	hlb_pix_if.sink                           pixel,
	hlb_res_if.source                         result
);

	// Configuration registers.
	hlb_pkg::blend_mode_t          blend_mode_q;
	logic [hlb_pkg::Q_W-1:0]       opacity_q;
	logic                          layer_visible_q;
	logic                          mask_enabled_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_mode_q    <= hlb_pkg::MODE_NORMAL;
			opacity_q       <= hlb_pkg::Q_ONE_U;
			layer_visible_q <= 1'b1;
			mask_enabled_q  <= 1'b0;
		end else if (cfg_wen) begin
			unique case (hlb_pkg::cfg_reg_t'(cfg_index))
				hlb_pkg::CFG_BLEND_MODE:    blend_mode_q <= hlb_pkg::blend_mode_t'(cfg_data[2:0]);
				hlb_pkg::CFG_OPACITY:       opacity_q <= cfg_data[hlb_pkg::Q_W-1:0];
				hlb_pkg::CFG_LAYER_VISIBLE: layer_visible_q <= cfg_data[0];
				hlb_pkg::CFG_MASK_ENABLED:  mask_enabled_q <= cfg_data[0];
			endcase
		end
	end

	// Pipeline flow control. Each stage advances when it is empty or when the
	// stage after it advances, so bubbles are squeezed out during a stall.
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;

	assign adv4 = !v_s4 || result.ready;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign pixel.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= pixel.valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	// Stage 1: combined factor k = opacity * mask and the overlay term.
	logic [hlb_pkg::Q_W-1:0]   opc_c;
	logic [hlb_pkg::Q_W-1:0]   msk_c;
	logic [33:0]               k_prod;
	logic                      pass_c;
	logic                      ov_low;
	logic signed [25:0]        ov_a;
	logic signed [24:0]        ov_b;
	logic signed [50:0]        ov_p;
	logic signed [34:0]        ov_q;
	logic signed [35:0]        t_c;

	always_comb begin
		opc_c = (opacity_q > hlb_pkg::Q_ONE_U) ? hlb_pkg::Q_ONE_U : opacity_q;
		if (!mask_enabled_q) begin
			msk_c = hlb_pkg::Q_ONE_U;
		end else begin
			msk_c = (pixel.mask_value > hlb_pkg::Q_ONE_U) ? hlb_pkg::Q_ONE_U
				: pixel.mask_value;
		end
		k_prod = 34'(opc_c) * 34'(msk_c);
		pass_c = !layer_visible_q || (opacity_q <= hlb_pkg::OPACITY_MIN);

		// Overlay: 2*b*l in the lower half, else ONE - 2*(ONE-b)*(ONE-l).
		ov_low = pixel.below_height < 24'(hlb_pkg::Q_HALF);
		if (ov_low) begin
			ov_a = 26'(pixel.below_height) <<< 1;
			ov_b = 25'(pixel.layer_height);
		end else begin
			ov_a = (26'(hlb_pkg::Q_ONE) - 26'(pixel.below_height)) <<< 1;
			ov_b = 25'(hlb_pkg::Q_ONE) - 25'(pixel.layer_height);
		end
		ov_p = ov_a * ov_b;
		ov_q = ov_p[50:16];
		t_c = ov_low ? 36'(ov_q) : 36'(hlb_pkg::Q_ONE) - 36'(ov_q);
	end

	logic signed [hlb_pkg::H_W-1:0] b_s1, l_s1;
	logic [hlb_pkg::Q_W-1:0]        k_s1;
	logic signed [35:0]             t_s1;
	hlb_pkg::blend_mode_t           mode_s1;
	logic                           pass_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			b_s1    <= pixel.below_height;
			l_s1    <= pixel.layer_height;
			k_s1    <= k_prod[32:16];
			t_s1    <= t_c;
			mode_s1 <= blend_mode_q;
			pass_s1 <= pass_c;
		end
	end

	// Stage 2: the mode picks the operand that the factor k scales.
	logic signed [36:0] xa;
	logic signed [17:0] k_sx;
	logic signed [54:0] pa_p;

	always_comb begin
		unique case (mode_s1)
			hlb_pkg::MODE_NORMAL:   xa = 37'(l_s1) - 37'(b_s1);
			hlb_pkg::MODE_ADD:      xa = 37'(l_s1);
			hlb_pkg::MODE_SUBTRACT: xa = 37'(l_s1);
			hlb_pkg::MODE_MULTIPLY: xa = 37'(l_s1) - 37'(hlb_pkg::Q_ONE);
			hlb_pkg::MODE_SCREEN:   xa = 37'(l_s1);
			hlb_pkg::MODE_MAX:      xa = (l_s1 > b_s1) ? 37'(l_s1) - 37'(b_s1) : 37'sd0;
			hlb_pkg::MODE_MIN:      xa = (l_s1 < b_s1) ? 37'(l_s1) - 37'(b_s1) : 37'sd0;
			hlb_pkg::MODE_OVERLAY:  xa = 37'(t_s1) - 37'(b_s1);
		endcase
		k_sx = signed'({1'b0, k_s1});
		pa_p = xa * k_sx;
	end

	logic signed [36:0]             pa_s2;
	logic signed [hlb_pkg::H_W-1:0] b_s2;
	hlb_pkg::blend_mode_t           mode_s2;
	logic                           pass_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			pa_s2   <= pa_p[52:16];
			b_s2    <= b_s1;
			mode_s2 <= mode_s1;
			pass_s2 <= pass_s1;
		end
	end

	// Stage 3: second product for multiply and screen, then the final sum.
	logic signed [25:0] yb;
	logic signed [24:0] zb;
	logic signed [50:0] pb_p;
	logic signed [34:0] pb;
	logic signed [38:0] r_c;

	always_comb begin
		if (mode_s2 == hlb_pkg::MODE_SCREEN) begin
			yb = 26'(hlb_pkg::Q_ONE) - 26'(pa_s2);
			zb = 25'(hlb_pkg::Q_ONE) - 25'(b_s2);
		end else begin
			yb = 26'(hlb_pkg::Q_ONE) + 26'(pa_s2);
			zb = 25'(b_s2);
		end
		pb_p = yb * zb;
		pb = pb_p[50:16];

		unique case (mode_s2)
			hlb_pkg::MODE_SUBTRACT: r_c = 39'(b_s2) - 39'(pa_s2);
			hlb_pkg::MODE_MULTIPLY: r_c = 39'(pb);
			hlb_pkg::MODE_SCREEN:   r_c = 39'(hlb_pkg::Q_ONE) - 39'(pb);
			hlb_pkg::MODE_NORMAL, hlb_pkg::MODE_ADD, hlb_pkg::MODE_MAX,
			hlb_pkg::MODE_MIN, hlb_pkg::MODE_OVERLAY:
				r_c = 39'(b_s2) + 39'(pa_s2);
		endcase
	end

	logic signed [38:0]             r_s3;
	logic signed [hlb_pkg::H_W-1:0] b_s3;
	logic                           pass_s3;

	always_ff @(posedge clk) begin
		if (adv3) begin
			r_s3    <= r_c;
			b_s3    <= b_s2;
			pass_s3 <= pass_s2;
		end
	end

	// Stage 4: saturate to the height range, or pass the height below through.
	logic signed [hlb_pkg::H_W-1:0] out_c;
	logic signed [hlb_pkg::H_W-1:0] blended_s4;

	always_comb begin
		priority if (pass_s3) begin
			out_c = b_s3;
		end else if (r_s3 > 39'(hlb_pkg::H_MAX)) begin
			out_c = hlb_pkg::H_MAX;
		end else if (r_s3 < 39'(hlb_pkg::H_MIN)) begin
			out_c = hlb_pkg::H_MIN;
		end else begin
			out_c = r_s3[hlb_pkg::H_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			blended_s4 <= out_c;
		end
	end

	assign result.valid          = v_s4;
	assign result.blended_height = blended_s4;

endmodule

// ===== bench/hlb_blend_checker.sv =====
// Checker for the height layer blend unit: tracks the register writes, predicts
// the composited height of every accepted pixel request and compares results.
// Depends on hlb_pkg, hlb_pix_if and hlb_res_if.
module hlb_blend_checker
	import hlb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	hlb_pix_if                    pixel,
	hlb_res_if                    result,
	output int                    fail_count,
	output int                    pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	// Shadow copy of the configuration registers.
	blend_mode_t      mode_q;
	logic [Q_W-1:0]   opacity_q;
	logic             visible_q;
	logic             mask_en_q;

	// Composited heights still owed by the block, oldest first.
	logic signed [H_W-1:0] owed_heights[$];

	// Q.16 product rounded toward minus infinity.
	function automatic longint q16_mul(input longint a, input longint b);
		return (a * b) >>> 16;
	endfunction

	function automatic logic signed [H_W-1:0] blend_height(
		input logic signed [H_W-1:0] below,
		input logic signed [H_W-1:0] layer,
		input logic        [Q_W-1:0] mask
	);
		longint b, l, m, op, k, t, r;
		b = below;
		l = layer;
		m = Q_ONE;
		if (mask_en_q)
			m = (mask > Q_ONE_U) ? Q_ONE : longint'(mask);
		r = b;
		if (visible_q && opacity_q > OPACITY_MIN) begin
			op = (opacity_q > Q_ONE_U) ? Q_ONE : longint'(opacity_q);
			k = q16_mul(op, m);
			case (mode_q)
				MODE_NORMAL:   r = b + q16_mul(l - b, k);
				MODE_ADD:      r = b + q16_mul(l, k);
				MODE_SUBTRACT: r = b - q16_mul(l, k);
				MODE_MULTIPLY: r = q16_mul(b, Q_ONE + q16_mul(l - Q_ONE, k));
				MODE_SCREEN:   r = Q_ONE - q16_mul(Q_ONE - b, Q_ONE - q16_mul(l, k));
				MODE_MAX:      r = b + q16_mul(((l > b) ? l : b) - b, k);
				MODE_MIN:      r = b + q16_mul(((l < b) ? l : b) - b, k);
				default: begin
					if (b < Q_HALF)
						t = q16_mul(2 * b, l);
					else
						t = Q_ONE - q16_mul(2 * (Q_ONE - b), Q_ONE - l);
					r = b + q16_mul(t - b, k);
				end
			endcase
		end
		if (r > longint'(H_MAX))
			r = H_MAX;
		if (r < longint'(H_MIN))
			r = H_MIN;
		return r[H_W-1:0];
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t ns checker: %s", $realtime, what);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q = MODE_NORMAL;
			opacity_q = Q_ONE_U;
			visible_q = 1'b1;
			mask_en_q = 1'b0;
			owed_heights.delete();
			fail_count = 0;
			pending_count = 0;
		end else begin
			if (pixel.valid && pixel.ready)
				owed_heights.push_back(blend_height(pixel.below_height,
					pixel.layer_height, pixel.mask_value));
			if (result.valid && result.ready) begin
				if (owed_heights.size() == 0)
					report_mismatch($sformatf("result %0d with no request pending",
						result.blended_height));
				else if (result.blended_height !== owed_heights[0]) begin
					report_mismatch($sformatf("blended_height %0d, predicted %0d",
						result.blended_height, owed_heights[0]));
					void'(owed_heights.pop_front());
				end else
					void'(owed_heights.pop_front());
			end
			if (cfg_wen) begin
				case (cfg_reg_t'(cfg_index))
					CFG_BLEND_MODE:    mode_q = blend_mode_t'(cfg_data[2:0]);
					CFG_OPACITY:       opacity_q = cfg_data[Q_W-1:0];
					CFG_LAYER_VISIBLE: visible_q = cfg_data[0];
					default:           mask_en_q = cfg_data[0];
				endcase
			end
			pending_count = owed_heights.size();
		end
	end
endmodule

// ===== bench/testbench.sv =====
// Top of the height layer blend testbench: clock, reset, register writes,
// pixel stimulus and result back-pressure, and the final verdict.
// Depends on hlb_pkg, both channel interfaces, the unit and hlb_blend_checker.
module testbench;
	import hlb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wen;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count;
	int                    pending_count;

	// When set, the pixel sender inserts random gaps between requests.
	bit sender_idles;
	// Set by the stimulus to ask the result side for one long hold-off.
	bit hold_off_request;

	hlb_pix_if pixel_ch();
	hlb_res_if result_ch();

	height_layer_blend_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel     (pixel_ch),
		.result    (result_ch)
	);

	// The checker sees exactly what the unit sees and keeps its own copy of the
	// registers, so the top only has to produce traffic.
	hlb_blend_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.pixel         (pixel_ch),
		.result        (result_ch),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop in case the unit hangs. The slowest legal run is well under a
	// tenth of this.
	initial begin
		#4000000;
		$display("tb: failure");
		$finish;
	end

	// Gap before a request: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(19);
		if (!sender_idles || roll < 10)
			return 0;
		if (roll < 18)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Heights lean toward the rails and toward the range around one, where the
	// overlay branch point and the multiply and screen modes are interesting.
	function automatic logic signed [H_W-1:0] pick_height();
		int roll;
		int near;
		logic [31:0] raw;
		roll = $urandom_range(7);
		near = int'($urandom_range(4 * Q_ONE)) - 2 * Q_ONE;
		raw = $urandom();
		if (roll == 0)
			return H_MAX;
		if (roll == 1)
			return H_MIN;
		if (roll < 4)
			return near[H_W-1:0];
		return raw[H_W-1:0];
	endfunction

	function automatic logic [Q_W-1:0] pick_mask();
		int roll;
		roll = $urandom_range(7);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return Q_ONE_U;
		if (roll == 2)
			return '1;
		return Q_W'($urandom_range(0, 2 * Q_ONE - 1));
	endfunction

	// Opacity values cluster on the pass-through threshold and the clamp.
	function automatic logic [Q_W-1:0] pick_opacity();
		case ($urandom_range(7))
			0: return '0;
			1: return OPACITY_MIN;
			2: return OPACITY_MIN + 1'b1;
			3: return Q_ONE_U;
			4: return '1;
			5: return Q_W'($urandom_range(0, 2 * Q_ONE - 1));
			default: return Q_W'($urandom_range(OPACITY_MIN + 1, Q_ONE));
		endcase
	endfunction

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wen = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_wen = 1'b0;
	endtask

	task automatic write_all(input blend_mode_t mode, input logic [Q_W-1:0] opacity,
		input logic visible, input logic mask_en);
		write_reg(CFG_BLEND_MODE, CFG_DATA_W'(mode));
		write_reg(CFG_OPACITY, opacity);
		write_reg(CFG_LAYER_VISIBLE, CFG_DATA_W'(visible));
		write_reg(CFG_MASK_ENABLED, CFG_DATA_W'(mask_en));
	endtask

	// Offers one pixel request and returns right after the edge that takes it.
	// Valid stays high into the next request when there is no gap.
	task automatic send_pixel(input logic signed [H_W-1:0] below,
		input logic signed [H_W-1:0] layer, input logic [Q_W-1:0] mask);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			pixel_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pixel_ch.valid = 1'b1;
		pixel_ch.below_height = below;
		pixel_ch.layer_height = layer;
		pixel_ch.mask_value = mask;
		do
			@(posedge clk);
		while (!pixel_ch.ready);
	endtask

	// Every request gives exactly one result, so once the checker owes nothing
	// the pipeline is empty; a few extra cycles are only a margin.
	task automatic drain();
		@(negedge clk);
		pixel_ch.valid = 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	// Result side: bursts of ready, random stalls, quiet stretches with no
	// stalls at all, and one long hold-off on request from the stimulus.
	// A ready burst is cut short as soon as the hold-off is asked for, so it
	// starts while the sender is still offering requests.
	initial begin
		int run;
		int stall;
		result_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				@(negedge clk);
				result_ch.ready = 1'b0;
				repeat (150) @(negedge clk);
			end
			run = ($urandom_range(7) == 0) ? 200 : $urandom_range(1, 30);
			@(negedge clk);
			result_ch.ready = 1'b1;
			repeat (run - 1) begin
				@(negedge clk);
				if (hold_off_request)
					break;
			end
			stall = $urandom_range(19);
			if (stall >= 10)
				stall = (stall < 18) ? $urandom_range(1, 3) : $urandom_range(8, 40);
			else
				stall = 0;
			if (stall > 0) begin
				@(negedge clk);
				result_ch.ready = 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
		end
	end

	initial begin
		int phase;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = CFG_BLEND_MODE;
		cfg_data = '0;
		pixel_ch.valid = 1'b0;
		pixel_ch.below_height = '0;
		pixel_ch.layer_height = '0;
		pixel_ch.mask_value = '0;
		sender_idles = 1'b0;
		hold_off_request = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. Out of reset the layer is a plain full-opacity normal
		// blend, so the result should simply be the layer height.
		send_pixel(H_MIN, H_MAX, '0);
		send_pixel(H_MAX, H_MIN, '1);
		drain();

		// One request per mode (two for overlay) with an over-range opacity and at
		// times an over-range mask, which clamp to one; add and subtract hit the rails.
		write_all(MODE_NORMAL, '1, 1'b1, 1'b1);
		send_pixel('0, H_MAX, '1);
		drain();
		write_reg(CFG_BLEND_MODE, CFG_DATA_W'(MODE_ADD));
		send_pixel(H_MAX, H_MAX, Q_ONE_U);
		drain();
		write_reg(CFG_BLEND_MODE, CFG_DATA_W'(MODE_SUBTRACT));
		send_pixel(H_MIN, H_MAX, '1);
		drain();
		write_reg(CFG_BLEND_MODE, CFG_DATA_W'(MODE_MULTIPLY));
		send_pixel(H_MAX, H_MIN, Q_ONE_U);
		drain();
		write_reg(CFG_BLEND_MODE, CFG_DATA_W'(MODE_SCREEN));
		send_pixel(H_MIN, H_MIN, '1);
		drain();
		write_reg(CFG_BLEND_MODE, CFG_DATA_W'(MODE_MAX));
		send_pixel(-24'sd5, 24'sd7, 17'd32768);
		drain();
		write_reg(CFG_BLEND_MODE, CFG_DATA_W'(MODE_MIN));
		send_pixel(24'sd9, -24'sd3, 17'd1);
		drain();
		// Overlay switches formula at one half, so hit both sides of it.
		write_reg(CFG_BLEND_MODE, CFG_DATA_W'(MODE_OVERLAY));
		send_pixel(24'(Q_HALF - 1), 24'(3 * Q_HALF), Q_ONE_U);
		send_pixel(24'(Q_HALF), 24'(Q_HALF), Q_ONE_U);
		drain();

		// A zero mask leaves the height below untouched through the product.
		send_pixel(24'sd12345, H_MAX, '0);
		drain();

		// Opacity right at the pass-through threshold, just above it, and zero.
		write_all(MODE_ADD, OPACITY_MIN, 1'b1, 1'b0);
		send_pixel(24'sd1000, H_MAX, '0);
		drain();
		write_reg(CFG_OPACITY, OPACITY_MIN + 1'b1);
		send_pixel(24'sd1000, H_MAX, '0);
		drain();
		write_reg(CFG_OPACITY, '0);
		send_pixel(H_MAX, H_MAX, '1);
		drain();

		// Hidden layer passes the height below through at full opacity.
		write_all(MODE_OVERLAY, Q_ONE_U, 1'b0, 1'b1);
		send_pixel(-24'sd77777, H_MIN, Q_ONE_U);
		drain();

		// Random part: twelve register settings of 125 requests each. The first
		// eight walk through every mode; later ones pick one at random. Every
		// third phase runs the sender without gaps, and the first of those also
		// holds the result side off long enough to fill the pipeline.
		for (phase = 0; phase < 12; phase++) begin
			write_all((phase < 8) ? blend_mode_t'(phase) : blend_mode_t'($urandom_range(7)),
				pick_opacity(), ($urandom_range(5) != 0), 1'($urandom_range(1)));
			sender_idles = (phase % 3 != 2);
			if (phase == 2)
				hold_off_request = 1'b1;
			repeat (125)
				send_pixel(pick_height(), pick_height(), pick_mask());
			drain();
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
